[rtl/gsp3_pkg.sv]
// ----------------------------------------------------------------------------
// gsp3_pkg
// Shared types and constants for the power-of-three series sum block.
// ----------------------------------------------------------------------------
package gsp3_pkg;

	localparam int RES_W = 30;
	localparam int MUL_W = 32;

	typedef logic [RES_W-1:0] residue_t;
	typedef logic [MUL_W-1:0] mul_op_t;

	localparam residue_t PRIME    = 30'd1000000007;
	localparam residue_t HALF_INV = 30'd500000004;
	localparam residue_t RATIO    = 30'd3;

	// floor(2^60 / PRIME), Barrett constant for a 30-bit modulus
	localparam logic [30:0] BARRETT_MU = 31'd1152921496;
	localparam logic [31:0] TWO_PRIME  = 32'd2000000014;

endpackage

[rtl/gsp3_modmul.sv]
// ----------------------------------------------------------------------------
// gsp3_modmul
// Modular multiplier: a * b mod PRIME on one shared 32x32 multiplier,
// reduced by Barrett's method in three multiplier passes and a correction.
// ----------------------------------------------------------------------------
module gsp3_modmul
	import gsp3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  residue_t a,
	input  residue_t b,
	output logic     done,
	output residue_t result
);

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_QUOT,
		MM_REM,
		MM_FIX
	} mm_state_t;

	mm_state_t      state_q;
	mul_op_t        mul_x;
	mul_op_t        mul_y;
	logic [63:0]    prod;
	logic [63:0]    prod_q;
	logic [31:0]    x_lo_q;
	logic [31:0]    rem;
	logic [31:0]    rem_fix;
	logic           done_q;
	residue_t       result_q;

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			MM_IDLE: begin
				mul_x = {2'b00, a};
				mul_y = {2'b00, b};
			end
			MM_QUOT: begin
				mul_x = {1'b0, prod_q[59:29]};
				mul_y = {1'b0, BARRETT_MU};
			end
			MM_REM: begin
				mul_x = {1'b0, prod_q[61:31]};
				mul_y = {2'b00, PRIME};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign prod = mul_x * mul_y;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	// remainder is below 3 * PRIME, so 32 bits hold it exactly
	assign rem = x_lo_q - prod_q[31:0];

	always_comb begin
		if (rem >= TWO_PRIME) begin
			rem_fix = rem - TWO_PRIME;
		end else if (rem >= {2'b00, PRIME}) begin
			rem_fix = rem - {2'b00, PRIME};
		end else begin
			rem_fix = rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MM_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			x_lo_q   <= '0;
		end else begin
			done_q <= (state_q == MM_FIX);
			unique case (state_q)
				MM_IDLE: begin
					if (start) begin
						state_q <= MM_QUOT;
					end
				end
				MM_QUOT: begin
					x_lo_q  <= prod_q[31:0];
					state_q <= MM_REM;
				end
				MM_REM: begin
					state_q <= MM_FIX;
				end
				MM_FIX: begin
					result_q <= rem_fix[RES_W-1:0];
					state_q  <= MM_IDLE;
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/geometric_sum_pow3_mod_prime.sv]
// ----------------------------------------------------------------------------
// geometric_sum_pow3_mod_prime
// Sum of 3^i for i = 0..n modulo 1000000007, via 3^(n+1) by LSB-first
// square-and-multiply, then (3^(n+1) - 1) times the inverse of two.
// It takes a multiply per set bit of n + 1, a squaring per bit below its top
// bit and one final scaling, each in turn on the shared multiplier unit.
// The block takes one item at a time; power_stall stays high until the
// result is queued in the output register. Reset clears the sequencer and
// empties the output register.
// ----------------------------------------------------------------------------
module geometric_sum_pow3_mod_prime
	import gsp3_pkg::*;
#(
	parameter int INPUT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  power_valid,
	output logic                  power_stall,
	input  logic [INPUT_BITS-1:0] highest_power,
	output logic                  sum_valid,
	input  logic                  sum_stall,
	output residue_t              series_sum
);

	localparam int EXP_W = INPUT_BITS + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_ACC,
		ST_SQ,
		ST_FIN,
		ST_PUT
	} state_t;

	state_t             state_q;
	logic [EXP_W-1:0]   exp_q;
	residue_t           acc_q;
	residue_t           sq_q;
	residue_t           sum_q;
	logic               sum_valid_q;
	logic               mm_start;
	residue_t           mm_a;
	residue_t           mm_b;
	logic               mm_done;
	residue_t           mm_res;
	logic               exp_zero;
	logic               slot_free;

	assign exp_zero  = (exp_q == '0);
	assign slot_free = !sum_valid_q || !sum_stall;
	assign mm_start  = (state_q == ST_STEP);

	// exponent exhausted: scale (acc - 1) by the inverse of two; else acc * sq on a set low bit, or sq * sq
	always_comb begin
		if (exp_zero) begin
			mm_a = acc_q - residue_t'(1);
			mm_b = HALF_INV;
		end else if (exp_q[0]) begin
			mm_a = acc_q;
			mm_b = sq_q;
		end else begin
			mm_a = sq_q;
			mm_b = sq_q;
		end
	end

	gsp3_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.done   (mm_done),
		.result (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_valid_q <= 1'b0;
			exp_q       <= '0;
			acc_q       <= '0;
			sq_q        <= '0;
			sum_q       <= '0;
		end else begin
			// drop the output beat once taken
			if (sum_valid_q && !sum_stall && state_q != ST_PUT) begin
				sum_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (power_valid) begin
						exp_q   <= {1'b0, highest_power} + EXP_W'(1);
						acc_q   <= residue_t'(1);
						sq_q    <= RATIO;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_zero) begin
						state_q <= ST_FIN;
					end else if (exp_q[0]) begin
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_ACC: begin
					if (mm_done) begin
						acc_q    <= mm_res;
						exp_q[0] <= 1'b0;
						state_q  <= ST_STEP;
					end
				end
				ST_SQ: begin
					if (mm_done) begin
						sq_q    <= mm_res;
						exp_q   <= exp_q >> 1;
						state_q <= ST_STEP;
					end
				end
				ST_FIN: begin
					if (mm_done) begin
						acc_q   <= mm_res;
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					// hold until the output register can take the beat
					if (slot_free) begin
						sum_q       <= acc_q;
						sum_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign power_stall = (state_q != ST_IDLE);
	assign sum_valid   = sum_valid_q;
	assign series_sum  = sum_q;

endmodule
